// ----- sv/lrupr_pkg.sv -----
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared types and fixed widths for the LRU page replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package lrupr_pkg;

	// fixed field widths
	localparam int CFG_W       = 5;
	localparam int FRAME_IDX_W = 4;
	localparam int FAULT_W     = 32;

	// controller states, one-hot
	typedef enum logic [1:0] {
		S_IDLE   = 2'b01,
		S_UPDATE = 2'b10
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;  // latch the incoming page reference
		logic commit;   // look up, update table, load result register
	} cmd_t;

endpackage

`default_nettype wire

// ----- sv/lrupr_if.sv -----
// ----------------------------------------------------------------------------
// lrupr_if
// Valid/ready channels for page references and lookup results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrupr_page_if #(parameter int PAGE_BITS = 16);
	logic                 valid;
	logic                 ready;
	logic [PAGE_BITS-1:0] page_number;

	modport source (output valid, output page_number, input ready);
	modport sink   (input valid, input page_number, output ready);
endinterface

interface lrupr_result_if #(parameter int PAGE_BITS = 16);
	logic                                  valid;
	logic                                  ready;
	logic                                  hit;
	logic [lrupr_pkg::FRAME_IDX_W-1:0]     frame_index;
	logic                                  evicted_valid;
	logic [PAGE_BITS-1:0]                  evicted_page;
	logic [lrupr_pkg::FAULT_W-1:0]         fault_count;

	modport source (output valid, output hit, output frame_index, output evicted_valid,
		output evicted_page, output fault_count, input ready);
	modport sink   (input valid, input hit, input frame_index, input evicted_valid,
		input evicted_page, input fault_count, output ready);
endinterface

`default_nettype wire

// ----- sv/lrupr_ctrl.sv -----
// ----------------------------------------------------------------------------
// lrupr_ctrl
// Sequencer: takes one reference, runs the table update, owns result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output lrupr_pkg::cmd_t      cmd
);

	lrupr_pkg::state_t state_q;
	logic              out_valid_q;
	logic              accept;
	logic              slot_free;

	// handshake decode
	assign in_ready    = (state_q == lrupr_pkg::S_IDLE);
	assign accept      = in_valid && in_ready;
	assign slot_free   = !out_valid_q || out_ready;
	assign cmd.capture = accept;
	assign cmd.commit  = (state_q == lrupr_pkg::S_UPDATE) && slot_free;
	assign out_valid   = out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrupr_pkg::S_IDLE;
		end else begin
			case (state_q)
				lrupr_pkg::S_IDLE: begin
					if (accept) state_q <= lrupr_pkg::S_UPDATE;
				end
				lrupr_pkg::S_UPDATE: begin
					if (slot_free) state_q <= lrupr_pkg::S_IDLE;
				end
				default: begin
					state_q <= lrupr_pkg::S_IDLE;
				end
			endcase
		end
	end

	// result valid: set on commit, cleared when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef ASSERT_OFF
	// one reference in flight: no new beat the cycle after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("reference accepted while another is in flight");

	// a result appears only out of the update step
	a_result_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == lrupr_pkg::S_UPDATE))
		else $error("result valid raised outside update step");

	// a waiting result beat stays up until taken
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("result beat dropped before it was taken");
`endif

endmodule

`default_nettype wire

// ----- sv/lrupr_dp.sv -----
// ----------------------------------------------------------------------------
// lrupr_dp
// Frame table, recency ranks, parallel lookup, victim pick and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_dp #(
	parameter int FRAMES    = 16,
	parameter int PAGE_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire lrupr_pkg::cmd_t                   cmd,
	input  wire logic [PAGE_BITS-1:0]              page_in,
	input  wire logic                              cfg_we,
	input  wire logic [lrupr_pkg::CFG_W-1:0]       cfg_wdata,
	output logic                                   res_hit,
	output logic [lrupr_pkg::FRAME_IDX_W-1:0]      res_frame,
	output logic                                   res_evicted,
	output logic [PAGE_BITS-1:0]                   res_evicted_page,
	output logic [lrupr_pkg::FAULT_W-1:0]          res_faults
);

	localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CNT_W  = $clog2(FRAMES + 1);
	localparam int RANK_W = IDX_W;

	// state
	logic [PAGE_BITS-1:0]            frame_page_q [FRAMES];
	logic [RANK_W-1:0]               rank_q       [FRAMES];
	logic [CNT_W-1:0]                filled_q;
	logic [lrupr_pkg::FAULT_W-1:0]   fault_q;
	logic [lrupr_pkg::CFG_W-1:0]     cfg_q;
	logic [PAGE_BITS-1:0]            page_q;

	// lookup and update terms
	logic [CNT_W-1:0]                n_act;
	logic [CNT_W-1:0]                filled;
	logic [FRAMES-1:0]               in_use;
	logic [FRAMES-1:0]               match;
	logic [FRAMES-1:0]               oldest;
	logic [FRAMES-1:0]               zero_rank;
	logic [IDX_W-1:0]                hit_idx;
	logic [IDX_W-1:0]                victim_idx;
	logic [IDX_W-1:0]                target;
	logic [RANK_W-1:0]               limit;
	logic                            hit;
	logic                            full;
	logic                            age_all;
	logic                            evict;
	logic [RANK_W-1:0]               rank_d [FRAMES];
	logic [CNT_W-1:0]                filled_d;
	logic [lrupr_pkg::FAULT_W-1:0]   fault_d;

	// active frame count, out-of-range values clamped
	always_comb begin
		if (cfg_q == '0) begin
			n_act = CNT_W'(1);
		end else if (32'(cfg_q) > FRAMES) begin
			n_act = CNT_W'(FRAMES);
		end else begin
			n_act = CNT_W'(cfg_q);
		end
	end

	assign filled = (filled_q < n_act) ? filled_q : n_act;
	assign full   = (filled == n_act);

	// per-frame compare against the referenced page and the oldest rank
	always_comb begin
		for (int i = 0; i < FRAMES; i++) begin
			in_use[i]    = (CNT_W'(i) < filled);
			match[i]     = in_use[i] && (frame_page_q[i] == page_q);
			oldest[i]    = in_use[i] && (rank_q[i] == RANK_W'(filled - CNT_W'(1)));
			zero_rank[i] = (CNT_W'(i) < filled_q) && (rank_q[i] == '0);
		end
	end

	// lowest matching frame, lowest oldest frame
	always_comb begin
		hit_idx    = '0;
		victim_idx = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (match[i])  hit_idx    = IDX_W'(i);
			if (oldest[i]) victim_idx = IDX_W'(i);
		end
	end

	assign hit = |match;

	// choose target frame and aging bound
	always_comb begin
		age_all = 1'b0;
		evict   = 1'b0;
		limit   = '0;
		if (hit) begin
			target = hit_idx;
			limit  = rank_q[hit_idx];
		end else if (!full) begin
			target  = IDX_W'(filled);
			age_all = 1'b1;
		end else begin
			target = victim_idx;
			limit  = RANK_W'(filled - CNT_W'(1));
			evict  = 1'b1;
		end
	end

	// next ranks: target becomes most recent, younger frames age by one
	always_comb begin
		for (int i = 0; i < FRAMES; i++) begin
			if (IDX_W'(i) == target) begin
				rank_d[i] = '0;
			end else if (in_use[i] && (age_all || (rank_q[i] < limit))) begin
				rank_d[i] = rank_q[i] + RANK_W'(1);
			end else begin
				rank_d[i] = rank_q[i];
			end
		end
	end

	assign filled_d = (!hit && !full) ? (filled + CNT_W'(1)) : filled;
	assign fault_d  = (!hit && (fault_q != '1)) ? (fault_q + 1'b1) : fault_q;

	// control state and ranks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q    <= lrupr_pkg::CFG_W'(16);
			filled_q <= '0;
			fault_q  <= '0;
			for (int i = 0; i < FRAMES; i++) rank_q[i] <= '0;
		end else if (cfg_we) begin
			cfg_q    <= cfg_wdata;
			filled_q <= '0;
			for (int i = 0; i < FRAMES; i++) rank_q[i] <= '0;
		end else if (cmd.commit) begin
			filled_q <= filled_d;
			fault_q  <= fault_d;
			for (int i = 0; i < FRAMES; i++) rank_q[i] <= rank_d[i];
		end
	end

	// page table, captured reference and result payload
	always_ff @(posedge clk) begin
		if (cmd.capture) page_q <= page_in;
		if (cmd.commit) begin
			if (!hit) frame_page_q[target] <= page_q;
			res_hit          <= hit;
			res_frame        <= lrupr_pkg::FRAME_IDX_W'(target);
			res_evicted      <= evict;
			res_evicted_page <= evict ? frame_page_q[victim_idx] : '0;
			res_faults       <= fault_d;
		end
	end

`ifndef ASSERT_OFF
	// fill count never runs past the active frame count
	a_filled_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= n_act)
		else $error("filled frame count exceeds active frames");

	// exactly one most-recent frame while the table holds pages
	a_single_mru: assert property (@(posedge clk) disable iff (!arst_n)
		(filled_q != '0) |-> $onehot(zero_rank))
		else $error("recency ranks lost their single most recent frame");

	// fill count moves only on an update or a frame count write
	a_filled_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(!cmd.commit && !cfg_we) |=> $stable(filled_q))
		else $error("filled frame count changed without an update");
`endif

endmodule

`default_nettype wire

// ----- sv/lru_page_replacement.sv -----
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative page-frame table with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each page reference is first registered from the beat, then, in the update
// step, every frame is compared in parallel, the victim is picked and all
// recency ranks are updated. One reference is in flight at a time; the result
// sits in an output register, and a new reference is refused until the
// update step has loaded it, so a stalled result sink holds off the next
// reference only while it keeps the previous result waiting. Writing
// cfg_wdata (frames in use, 0 acts as 1, above FRAMES acts as FRAMES)
// empties the table and keeps the fault count; there is no
// clearing pass after reset. frame_index reports the low four bits of the
// frame number.
`default_nettype none

module lru_page_replacement #(
	parameter int FRAMES    = 16,
	parameter int PAGE_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	lrupr_page_if.sink                         pages,
	lrupr_result_if.source                     results,
	input  wire logic                          cfg_we,
	input  wire logic [lrupr_pkg::CFG_W-1:0]   cfg_wdata
);

	lrupr_pkg::cmd_t cmd;

	// sequencer
	lrupr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pages.valid),
		.in_ready  (pages.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd)
	);

	// table and result datapath
	lrupr_dp #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.page_in          (pages.page_number),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.res_hit          (results.hit),
		.res_frame        (results.frame_index),
		.res_evicted      (results.evicted_valid),
		.res_evicted_page (results.evicted_page),
		.res_faults       (results.fault_count)
	);

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LRU page replacement table.
// ----------------------------------------------------------------------------
// Page references go in on the valid/ready page channel. Each accepted beat
// runs through a local LRU table that keeps its own frames, age ranks,
// fill level and fault total. The expected lookup is queued and compared
// field by field with the result beat. The frame count register is only
// rewritten once the table is idle. Small and out-of-range counts are
// covered, and so is a long stall on the result side.

module tb;

	localparam int FRAMES     = 16;
	localparam int PAGE_BITS  = 16;
	localparam int MAX_CYCLES = 400000;
	localparam int WS_SIZE    = 24;

	typedef logic [PAGE_BITS-1:0] page_t;

	typedef struct packed {
		logic                              hit;
		logic [lrupr_pkg::FRAME_IDX_W-1:0] frame_index;
		logic                              evicted_valid;
		page_t                             evicted_page;
		logic [lrupr_pkg::FAULT_W-1:0]     fault_count;
	} lookup_t;

	// LRU table predictor plus the queue of lookups still owed by the block
	class lru_table_model;
		page_t                         held_page[FRAMES];
		logic [3:0]                    age[FRAMES];
		logic [4:0]                    filled;
		logic [lrupr_pkg::FAULT_W-1:0] faults;
		logic [lrupr_pkg::CFG_W-1:0]   frames_cfg;
		lookup_t                       expected_lookups[$];
		int                            errors;
		int                            refs;
		int                            hits;
		int                            evictions;

		function new();
			foreach (held_page[i]) held_page[i] = '0;
			foreach (age[i]) age[i] = '0;
			filled     = '0;
			faults     = '0;
			frames_cfg = lrupr_pkg::CFG_W'(FRAMES);
			errors     = 0;
			refs       = 0;
			hits       = 0;
			evictions  = 0;
		endfunction

		function int active_frames();
			if (frames_cfg == 0) return 1;
			if (frames_cfg > FRAMES) return FRAMES;
			return int'(frames_cfg);
		endfunction

		// a write empties the table but keeps the fault total
		function void set_frames(logic [lrupr_pkg::CFG_W-1:0] value);
			frames_cfg = value;
			foreach (age[i]) age[i] = '0;
			filled = '0;
		endfunction

		function int pending();
			return expected_lookups.size();
		endfunction

		function void note(page_t page);
			int      n;
			int      fill;
			int      tgt;
			int      lim;
			int      i;
			bit      found;
			lookup_t r;
			n     = active_frames();
			fill  = (filled < n) ? int'(filled) : n;
			r     = '0;
			tgt   = 0;
			found = 0;
			for (i = 0; i < fill; i++) begin
				if (!found && held_page[i] == page) begin
					found = 1;
					tgt   = i;
				end
			end
			if (found) begin
				// only frames newer than the hit frame get older
				lim   = int'(age[tgt]);
				r.hit = 1'b1;
				hits++;
			end else begin
				if (faults != '1) faults++;
				if (fill < n) begin
					tgt    = fill;
					fill++;
					filled = 5'(fill);
					lim    = FRAMES + 1;
				end else begin
					// victim is the frame with the oldest rank
					for (i = 0; i < fill; i++) begin
						if (!r.evicted_valid && age[i] == 4'(fill - 1)) begin
							tgt             = i;
							r.evicted_valid = 1'b1;
						end
					end
					if (!r.evicted_valid) tgt = 0;
					r.evicted_valid = 1'b1;
					r.evicted_page  = held_page[tgt];
					lim             = fill - 1;
					evictions++;
				end
				held_page[tgt] = page;
			end
			for (i = 0; i < fill; i++) begin
				if (i != tgt && int'(age[i]) < lim) age[i]++;
			end
			age[tgt]      = '0;
			r.frame_index = lrupr_pkg::FRAME_IDX_W'(tgt);
			r.fault_count = faults;
			expected_lookups = {expected_lookups, r};
			refs++;
		endfunction

		function void check(lookup_t act);
			lookup_t exp_r;
			if (expected_lookups.size() == 0) begin
				$error("result beat with no reference outstanding");
				errors++;
				return;
			end
			exp_r = expected_lookups.pop_front();
			if (act.hit !== exp_r.hit) begin
				$error("hit: expected %0d, got %0d", exp_r.hit, act.hit);
				errors++;
			end
			if (act.frame_index !== exp_r.frame_index) begin
				$error("frame_index: expected %0d, got %0d", exp_r.frame_index,
					act.frame_index);
				errors++;
			end
			if (act.evicted_valid !== exp_r.evicted_valid) begin
				$error("evicted_valid: expected %0d, got %0d", exp_r.evicted_valid,
					act.evicted_valid);
				errors++;
			end
			if (act.evicted_page !== exp_r.evicted_page) begin
				$error("evicted_page: expected %h, got %h", exp_r.evicted_page,
					act.evicted_page);
				errors++;
			end
			if (act.fault_count !== exp_r.fault_count) begin
				$error("fault_count: expected %0d, got %0d", exp_r.fault_count,
					act.fault_count);
				errors++;
			end
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [lrupr_pkg::CFG_W-1:0] cfg_wdata;
	int                          cycles;
	int                          src_idle_pct;
	int                          sink_idle_pct;
	int                          hold_left;
	int                          cfg_writes;
	page_t                       work_set[WS_SIZE];
	lru_table_model              lru;

	lrupr_page_if   #(.PAGE_BITS(PAGE_BITS)) page_ch ();
	lrupr_result_if #(.PAGE_BITS(PAGE_BITS)) result_ch ();

	lru_page_replacement #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pages     (page_ch.sink),
		.results   (result_ch.source),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// result sink: long hold first, otherwise random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			result_ch.ready <= 1'b0;
			hold_left--;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// result beats
	always @(posedge clk) begin
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			lru.check('{hit: result_ch.hit, frame_index: result_ch.frame_index,
				evicted_valid: result_ch.evicted_valid,
				evicted_page: result_ch.evicted_page,
				fault_count: result_ch.fault_count});
		end
	end

	// offer one page reference, with a random gap in front
	task automatic send_ref(input page_t page);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			page_ch.valid <= 1'b0;
			@(negedge clk);
		end
		page_ch.valid       <= 1'b1;
		page_ch.page_number <= page;
		do @(posedge clk); while (page_ch.ready !== 1'b1);
		lru.note(page);
	endtask

	// drop valid and wait until every owed lookup is back
	task automatic drain();
		@(negedge clk);
		page_ch.valid <= 1'b0;
		while (lru.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// frame count write, only with the table idle
	task automatic write_frames(input logic [lrupr_pkg::CFG_W-1:0] value);
		drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		lru.set_frames(value);
		cfg_writes++;
		@(posedge clk);
	endtask

	// mostly pages from a working set sized around the frame count
	function automatic page_t pick_page(int n);
		int roll;
		int span;
		roll = $urandom_range(99);
		span = (n + 3 < WS_SIZE) ? n + 3 : WS_SIZE - 1;
		if (roll < 75) return work_set[$urandom_range(span)];
		if (roll < 85) return work_set[$urandom_range(WS_SIZE - 1)];
		if (roll < 88) return '1;
		if (roll < 90) return '0;
		return PAGE_BITS'($urandom);
	endfunction

	initial begin
		logic [lrupr_pkg::CFG_W-1:0] phase_cfg[7];
		int                          ph;
		int                          k;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		page_ch.valid       = 1'b0;
		page_ch.page_number = '0;
		result_ch.ready     = 1'b0;
		cycles              = 0;
		src_idle_pct        = 0;
		sink_idle_pct       = 0;
		hold_left           = 0;
		cfg_writes          = 0;
		lru                 = new();
		phase_cfg           = '{5'd31, 5'd4, 5'd1, 5'd17, 5'd9, 5'd2, 5'd16};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset frame count, all-zero and all-one pages, hits
		src_idle_pct  = 10;
		sink_idle_pct = 49;
		send_ref(16'h0000);
		send_ref(16'hFFFF);
		send_ref(16'h0000);
		send_ref(16'hAAAA);
		send_ref(16'h5555);
		send_ref(16'hFFFF);

		// two frames: eviction of the oldest in both slots
		write_frames(5'd2);
		send_ref(16'h0001);
		send_ref(16'h0002);
		send_ref(16'h0001);
		send_ref(16'h0003);
		send_ref(16'h0002);
		send_ref(16'h0003);

		// count of zero acts as a single frame
		write_frames(5'd0);
		send_ref(16'h1234);
		send_ref(16'h1234);
		send_ref(16'h4321);

		// random phases over several frame counts and idle mixes
		for (ph = 0; ph < 7; ph++) begin
			foreach (work_set[i]) work_set[i] = PAGE_BITS'($urandom);
			write_frames(phase_cfg[ph]);
			if (ph < 3) begin
				src_idle_pct  = 10;
				sink_idle_pct = 49;
			end else if (ph < 5) begin
				src_idle_pct  = 49;
				sink_idle_pct = 10;
			end else begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			// long sink stall so the block backs up onto the page channel
			if (ph == 1) hold_left = 300;
			for (k = 0; k < 200; k++) send_ref(pick_page(lru.active_frames()));
		end

		drain();
		repeat (10) @(posedge clk);
		$display("covered %0d references (%0d hits, %0d evictions), %0d frame count writes",
			lru.refs, lru.hits, lru.evictions, cfg_writes);
		$display("final fault total %0d, %0d field mismatches", lru.faults, lru.errors);
		if (lru.errors == 0 && lru.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
sv/lrupr_pkg.sv
sv/lrupr_if.sv
sv/lrupr_ctrl.sv
sv/lrupr_dp.sv
sv/lru_page_replacement.sv
dv/tb.sv
